// ----- src/skst_pkg.sv -----
// ----------------------------------------------------------------------------
// skst_pkg
// Shared constants and payload types of the streaming k-th smallest tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package skst_pkg;

  localparam int K_MAX      = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int FILL_W     = $clog2(K_MAX + 1);
  localparam int LFT_W      = ADDR_W + 1;
  localparam int K_SEL_W    = 11;
  localparam int K_RESET    = 1000;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] sample_value;
    logic                         end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] kth_smallest;
    logic                         enough_items;
  } out_item_t;

endpackage

`default_nettype wire

// ----- src/skst_ram.sv -----
// ----------------------------------------------------------------------------
// skst_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module skst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           wr_en,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]               wr_data,
  input  wire logic                           rd_en,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic      [WIDTH-1:0]               rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- src/stream_kth_smallest_tracker.sv -----
// ----------------------------------------------------------------------------
// stream_kth_smallest_tracker
// Keeps the k smallest values of a stream in a RAM-based max-heap and reports
// the k-th smallest value when the stream ends.
// ----------------------------------------------------------------------------
// Usage:
//   in_item carries one signed value and an end-of-stream mark; a transfer
//   happens when in_valid is high and in_stall is low. in_stall stays high
//   while an item is being worked on.
//   The first k values of a stream are inserted and sifted up; after that a
//   value below the heap top replaces the top and sinks down. Going up, each
//   heap level reads the parent, then compares and writes; going down, it
//   reads the left child, then the right child, then compares and writes, all
//   on one RAM port pair.
//   An end-marked item yields one out_item from the finish step after its heap update:
//   the heap top with enough_items high, or -1 with enough_items low when
//   fewer than k items arrived. The fill count then clears for the next stream.
//   The result sits in an output register; the next item is taken while it
//   waits. If out_stall holds a result and another end-marked item finishes,
//   the block waits until the register frees.
//   cfg_wr_en writes k (0 acts as 1, above the heap size acts as the heap size)
//   and restarts the current stream. Reset sets k to 1000 and empties the heap;
//   heap RAM contents are not cleared and are read only after being written.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_kth_smallest_tracker
  import skst_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_item,
  input  wire logic                 cfg_wr_en,
  input  wire logic [K_SEL_W-1:0]   cfg_wr_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP_RD  = 3'd1;
  localparam logic [2:0] S_UP_CMP = 3'd2;
  localparam logic [2:0] S_DN_L   = 3'd3;
  localparam logic [2:0] S_DN_R   = 3'd4;
  localparam logic [2:0] S_DN_CMP = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0]                   state_r, state_nxt;
  logic [ADDR_W-1:0]            pos_r, pos_nxt;
  logic [ADDR_W-1:0]            lft_r, lft_nxt;
  logic signed [DATA_WIDTH-1:0] val_r, val_nxt;
  logic signed [DATA_WIDTH-1:0] lval_r, lval_nxt;
  logic signed [DATA_WIDTH-1:0] top_r, top_nxt;
  logic                         rgt_r, rgt_nxt;
  logic                         eos_r, eos_nxt;
  logic [FILL_W-1:0]            fill_r, fill_nxt;
  logic [K_SEL_W-1:0]           k_r;
  logic                         out_valid_r, out_valid_nxt;
  out_item_t                    out_item_r, out_item_nxt;

  logic [FILL_W-1:0]            k_eff;
  logic                         in_xfer;
  logic                         slot_free;
  logic [LFT_W-1:0]             lft_full;
  logic signed [DATA_WIDTH-1:0] rd_val;
  logic signed [DATA_WIDTH-1:0] big_val;
  logic [ADDR_W-1:0]            big_addr;

  logic                         wr_en;
  logic [ADDR_W-1:0]            wr_addr;
  logic [DATA_WIDTH-1:0]        wr_data;
  logic                         rd_en;
  logic [ADDR_W-1:0]            rd_addr;
  logic [DATA_WIDTH-1:0]        rd_data;

  skst_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (K_MAX)
  ) u_heap (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    if (32'(k_r) > K_MAX) begin
      k_eff = FILL_W'(K_MAX);
    end else if (k_r == '0) begin
      k_eff = FILL_W'(1);
    end else begin
      k_eff = FILL_W'(k_r);
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign lft_full  = {pos_r, 1'b1};
  assign rd_val    = $signed(rd_data);

  // larger child; right child only counts when it exists
  always_comb begin
    if (rgt_r && (rd_val > lval_r)) begin
      big_val  = rd_val;
      big_addr = lft_r + ADDR_W'(1);
    end else begin
      big_val  = lval_r;
      big_addr = lft_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    lft_nxt       = lft_r;
    val_nxt       = val_r;
    lval_nxt      = lval_r;
    rgt_nxt       = rgt_r;
    eos_nxt       = eos_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = val_r;
    rd_en         = 1'b0;
    rd_addr       = lft_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          val_nxt = in_item.sample_value;
          eos_nxt = in_item.end_of_stream;
          if (fill_r < k_eff) begin
            pos_nxt   = fill_r[ADDR_W-1:0];
            fill_nxt  = fill_r + FILL_W'(1);
            state_nxt = S_UP_RD;
          end else if (in_item.sample_value < top_r) begin
            pos_nxt   = '0;
            state_nxt = S_DN_L;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_UP_RD: begin
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          state_nxt = S_FIN;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = (pos_r - ADDR_W'(1)) >> 1;
          lft_nxt   = rd_addr;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        // parent below the new value moves down into the hole
        if (rd_val < val_r) begin
          wr_data   = rd_data;
          pos_nxt   = lft_r;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DN_L: begin
        if (lft_full >= LFT_W'(fill_r)) begin
          wr_en     = 1'b1;
          state_nxt = S_FIN;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = lft_full[ADDR_W-1:0];
          lft_nxt   = lft_full[ADDR_W-1:0];
          state_nxt = S_DN_R;
        end
      end
      S_DN_R: begin
        lval_nxt  = rd_val;
        rgt_nxt   = (LFT_W'(lft_r) + LFT_W'(1)) < LFT_W'(fill_r);
        rd_en     = rgt_nxt;
        rd_addr   = lft_r + ADDR_W'(1);
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (big_val > val_r) begin
          wr_data   = big_val;
          pos_nxt   = big_addr;
          state_nxt = S_DN_L;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!eos_r) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (fill_r >= k_eff) begin
            out_item_nxt.kth_smallest = top_r;
            out_item_nxt.enough_items = 1'b1;
          end else begin
            out_item_nxt.kth_smallest = '1;
            out_item_nxt.enough_items = 1'b0;
          end
          fill_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a new rank restarts the stream
    if (cfg_wr_en) begin
      fill_nxt = '0;
    end
  end

  // heap top mirrored in a register
  always_comb begin
    top_nxt = top_r;
    if (wr_en && (wr_addr == '0)) begin
      top_nxt = $signed(wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      k_r         <= K_SEL_W'(K_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        k_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    lft_r      <= lft_nxt;
    val_r      <= val_nxt;
    lval_r     <= lval_nxt;
    rgt_r      <= rgt_nxt;
    eos_r      <= eos_nxt;
    top_r      <= top_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // fill count never passes the active rank
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= k_eff)
    else $error("heap fill count exceeds rank");

  // heap writes stay inside the filled region
  a_wr_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (FILL_W'(wr_addr) < fill_r))
    else $error("heap write outside filled entries");

  // a result only appears out of the finish step
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result raised outside finish step");

  // a right child is only considered when it exists
  a_rgt_exists: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DN_CMP && rgt_r) |-> ((LFT_W'(lft_r) + LFT_W'(1)) < LFT_W'(fill_r)))
    else $error("right child beyond heap fill");

endmodule

`default_nettype wire
